### rtl/core/md2he_pkg.sv
// ----------------------------------------------------------------------------
// md2he_pkg
// Shared constants and the MD2 substitution table for the hash engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package md2he_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int STATE_BYTES = 48;
  localparam int ROUNDS      = 18;
  localparam int STATE_AW    = $clog2(STATE_BYTES);
  localparam int BLOCK_AW    = $clog2(BLOCK_BYTES);
  localparam int ROUND_W     = $clog2(ROUNDS);

  localparam logic [7:0] SBOX [0:255] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

  function automatic logic [7:0] sbox(input logic [7:0] a);
    return SBOX[a];
  endfunction

endpackage

`default_nettype wire

### rtl/core/md2he_ram.sv
// ----------------------------------------------------------------------------
// md2he_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module md2he_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/md2_hash_engine.sv
// ----------------------------------------------------------------------------
// md2_hash_engine
// MD2 digest of a byte stream: collects 16-byte blocks, compresses each with
// 18 substitution rounds over a 48-byte state, and emits a 16-byte digest.
// ----------------------------------------------------------------------------
//  Channel | Dir | tdata           | tuser      | tlast
//  s_*     | in  | data_byte [7:0] | byte_valid | last
//  m_*     | out | digest_byte     | -          | digest_last
//
//  A data block loads the state, primes the RAM, then runs 864 table lookups
//  (one state byte updated per cycle) and 16 checksum steps.
//  A final message adds a pad step, the padded block, the checksum block and
//  per digest beat a read, load and wait step, which stalls on the output.
//  Reset clears state validity, checksum and fill count.
//  s_tready is high only while the engine is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module md2_hash_engine (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tuser,   // [0] byte_valid
  input  wire logic       s_tlast,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata,   // [7:0] digest_byte
  output logic            m_tlast
);

  import md2he_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SETUP    = 4'd1;
  localparam logic [3:0] S_PRIME    = 4'd2;
  localparam logic [3:0] S_ROUND    = 4'd3;
  localparam logic [3:0] S_CSUM     = 4'd4;
  localparam logic [3:0] S_PAD      = 4'd5;
  localparam logic [3:0] S_OUT_RD   = 4'd6;
  localparam logic [3:0] S_OUT_LD   = 4'd7;
  localparam logic [3:0] S_OUT_WAIT = 4'd8;

  localparam logic [1:0] K_DATA = 2'd0;
  localparam logic [1:0] K_PAD  = 2'd1;
  localparam logic [1:0] K_CSUM = 2'd2;

  localparam logic [STATE_AW-1:0] LAST_K     = STATE_AW'(STATE_BYTES - 1);
  localparam logic [ROUND_W-1:0]  LAST_R     = ROUND_W'(ROUNDS - 1);
  localparam logic [BLOCK_AW-1:0] LAST_J     = BLOCK_AW'(BLOCK_BYTES - 1);
  localparam logic [BLOCK_AW:0]   BLOCK_SIZE = (BLOCK_AW+1)'(BLOCK_BYTES);

  logic [3:0]          state;
  logic [1:0]          kind;
  logic                fin;
  logic                sub;
  logic [BLOCK_AW-1:0] fill;
  logic [BLOCK_AW-1:0] j;
  logic [STATE_AW-1:0] k;
  logic [ROUND_W-1:0]  r;
  logic [7:0]          t;
  logic [7:0]          blk [BLOCK_BYTES];
  logic [7:0]          cs [BLOCK_BYTES];
  logic [STATE_BYTES-1:0] hs_valid;
  logic                rd_vld;
  logic [7:0]          out_data;
  logic                out_valid;
  logic                out_last;

  logic                ram_we;
  logic [STATE_AW-1:0] ram_waddr;
  logic [7:0]          ram_wdata;
  logic [STATE_AW-1:0] ram_raddr;
  logic [7:0]          ram_rdata;
  logic [7:0]          hs_rd;
  logic [7:0]          m_byte;
  logic [7:0]          round_new;
  logic [7:0]          cs_new;
  logic [7:0]          pad_byte;
  logic                in_beat;

  md2he_ram #(
    .WIDTH (8),
    .DEPTH (STATE_BYTES)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready  = (state == S_IDLE);
  assign in_beat   = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;
  assign m_tlast   = out_last;

  assign hs_rd     = rd_vld ? ram_rdata : 8'd0;
  assign m_byte    = (kind == K_CSUM) ? cs[j] : blk[j];
  assign round_new = hs_rd ^ sbox(t);
  assign cs_new    = cs[j] ^ sbox(m_byte ^ t);
  assign pad_byte  = 8'(BLOCK_SIZE - {1'b0, fill});

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k;
    ram_wdata = round_new;
    ram_raddr = '0;
    case (state)
      S_SETUP: begin
        ram_we    = 1'b1;
        ram_raddr = STATE_AW'(j);
        if (!sub) begin
          ram_waddr = STATE_AW'(BLOCK_BYTES) + STATE_AW'(j);
          ram_wdata = m_byte;
        end else begin
          ram_waddr = STATE_AW'(2 * BLOCK_BYTES) + STATE_AW'(j);
          ram_wdata = m_byte ^ hs_rd;
        end
      end
      S_PRIME: begin
        ram_raddr = '0;
      end
      S_ROUND: begin
        ram_we    = 1'b1;
        ram_raddr = (k == LAST_K) ? '0 : k + 1'b1;
      end
      S_OUT_RD: begin
        ram_raddr = STATE_AW'(j);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_vld <= hs_valid[ram_raddr];
    if (rst) begin
      state     <= S_IDLE;
      hs_valid  <= '0;
      fill      <= '0;
      fin       <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        cs[i] <= 8'd0;
      end
    end else begin
      if (ram_we) begin
        hs_valid[ram_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            fin <= s_tlast;
            if (s_tuser) begin
              blk[fill] <= s_tdata;
              if (fill == LAST_J) begin
                fill  <= '0;
                kind  <= K_DATA;
                j     <= '0;
                sub   <= 1'b0;
                state <= S_SETUP;
              end else begin
                fill <= fill + 1'b1;
                if (s_tlast) begin
                  state <= S_PAD;
                end
              end
            end else if (s_tlast) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          for (int i = 0; i < BLOCK_BYTES; i++) begin
            if (BLOCK_AW'(i) >= fill) begin
              blk[i] <= pad_byte;
            end
          end
          fill  <= '0;
          kind  <= K_PAD;
          j     <= '0;
          sub   <= 1'b0;
          state <= S_SETUP;
        end
        S_SETUP: begin
          sub <= ~sub;
          if (sub) begin
            j <= j + 1'b1;
            if (j == LAST_J) begin
              state <= S_PRIME;
            end
          end
        end
        S_PRIME: begin
          k     <= '0;
          r     <= '0;
          t     <= 8'd0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          if (k == LAST_K) begin
            k <= '0;
            r <= r + 1'b1;
            t <= round_new + 8'(r);
            if (r == LAST_R) begin
              j <= '0;
              if (kind == K_CSUM) begin
                state <= S_OUT_RD;
              end else begin
                t     <= cs[LAST_J];
                state <= S_CSUM;
              end
            end
          end else begin
            k <= k + 1'b1;
            t <= round_new;
          end
        end
        S_CSUM: begin
          cs[j] <= cs_new;
          t     <= cs_new;
          j     <= j + 1'b1;
          if (j == LAST_J) begin
            j <= '0;
            if (kind == K_PAD) begin
              kind  <= K_CSUM;
              sub   <= 1'b0;
              state <= S_SETUP;
            end else if (fin) begin
              state <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_LD;
        end
        S_OUT_LD: begin
          out_data  <= hs_rd;
          out_last  <= (j == LAST_J);
          out_valid <= 1'b1;
          state     <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (m_tready) begin
            out_valid <= 1'b0;
            if (j == LAST_J) begin
              hs_valid <= '0;
              fill     <= '0;
              fin      <= 1'b0;
              for (int i = 0; i < BLOCK_BYTES; i++) begin
                cs[i] <= 8'd0;
              end
              state <= S_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while a digest beat is pending");

  a_idle_after_digest: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("engine not idle after the final digest beat");

  a_round_ports_apart: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> ram_waddr != ram_raddr)
    else $error("state RAM read and write collide during a round");

  a_load_before_valid: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_OUT_LD)
    else $error("digest beat raised outside the load step");
`endif

endmodule

`default_nettype wire

### test/md2_hash_engine_tb.sv
// ----------------------------------------------------------------------------
// md2_hash_engine_tb
// Self-checking testbench for the MD2 hash engine. Messages are streamed in
// byte by byte, and a software MD2 model predicts the 16 digest beats of each
// message. Every beat is checked against the prediction while both stream
// sides idle at random and the output side is held off for long stretches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module md2_hash_engine_tb;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 2000;
  localparam int MAX_REPORTS = 50;

  localparam logic [7:0] PI_SUBST [0:255] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } digest_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic       s_tuser = 1'b0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  logic [7:0] msg_block [16];
  logic [7:0] hash_st [48];
  logic [7:0] cksum [16];
  int         fill_cnt = 0;

  digest_beat_t digest_q [$];
  int           err_count = 0;
  int           items_sent = 0;
  int           cycle_count = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  logic         rx_hold = 1'b0;

  md2_hash_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d digest beats pending",
               cycle_count, digest_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void clear_hash_state();
    fill_cnt = 0;
    for (int i = 0; i < 16; i++) begin
      msg_block[i] = 8'd0;
      cksum[i] = 8'd0;
    end
    for (int i = 0; i < 48; i++) begin
      hash_st[i] = 8'd0;
    end
  endfunction

  function automatic void md2_compress(input logic [7:0] m [16]);
    logic [7:0] t;
    for (int j = 0; j < 16; j++) begin
      hash_st[16 + j] = m[j];
      hash_st[32 + j] = m[j] ^ hash_st[j];
    end
    t = 8'd0;
    for (int r = 0; r < 18; r++) begin
      for (int k = 0; k < 48; k++) begin
        hash_st[k] = hash_st[k] ^ PI_SUBST[t];
        t = hash_st[k];
      end
      t = t + 8'(r);
    end
    t = cksum[15];
    for (int j = 0; j < 16; j++) begin
      cksum[j] = cksum[j] ^ PI_SUBST[m[j] ^ t];
      t = cksum[j];
    end
  endfunction

  // Absorbs one accepted beat and queues the digest when the message ends.
  function automatic void absorb_beat(input logic [7:0] b, input logic v, input logic l);
    logic [7:0] pad;
    digest_beat_t d;
    if (v) begin
      msg_block[fill_cnt] = b;
      fill_cnt++;
      if (fill_cnt == 16) begin
        md2_compress(msg_block);
        fill_cnt = 0;
      end
    end
    if (l) begin
      pad = 8'(16 - fill_cnt);
      for (int i = fill_cnt; i < 16; i++) begin
        msg_block[i] = pad;
      end
      md2_compress(msg_block);
      md2_compress(cksum);
      for (int i = 0; i < 16; i++) begin
        d.value = hash_st[i];
        d.is_last = (i == 15);
        digest_q.push_back(d);
      end
      clear_hash_state();
    end
  endfunction

  task automatic report_mismatch(input string what, input int expected, input int got);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h", $time, what, expected, got);
    end
  endtask

  always @(posedge clk) begin
    digest_beat_t d;
    if (m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("digest beat with nothing pending", 0, m_tdata);
      end else begin
        d = digest_q.pop_front();
        if (m_tdata !== d.value) begin
          report_mismatch("digest_byte", d.value, m_tdata);
        end
        if (m_tlast !== d.is_last) begin
          report_mismatch("digest_last", d.is_last, m_tlast);
        end
      end
    end
    if (rx_hold) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic v, input logic l);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= v;
    s_tlast <= l;
    do @(posedge clk); while (!s_tready);
    absorb_beat(b, v, l);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (digest_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // A message either ends on its final byte or with a separate empty beat.
  task automatic send_message(input int nbytes);
    int body;
    logic byte_on_last;
    byte_on_last = (nbytes > 0) && ($urandom_range(0, 1) == 1);
    body = nbytes - int'(byte_on_last);
    for (int i = 0; i < body; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(8'($urandom), 1'b0, 1'b0);
      end
      send_beat(8'($urandom), 1'b1, 1'b0);
    end
    send_beat(8'($urandom), byte_on_last, 1'b1);
  endtask

  function automatic int pick_length();
    case ($urandom_range(0, 7))
      0: return 15 + 16 * $urandom_range(0, 1) + $urandom_range(0, 2);
      1: return $urandom_range(18, 48);
      default: return $urandom_range(0, 14);
    endcase
  endfunction

  task automatic test_corner_messages();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b0);
    send_beat(8'hA5, 1'b1, 1'b1);
    // A full block followed by an empty closing beat pads a whole block.
    for (int i = 0; i < 16; i++) begin
      send_beat(8'(i * 17), 1'b1, 1'b0);
    end
    send_beat(8'h00, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_messages(input int target, input int tx_pct, input int rx_pct);
    int start;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = items_sent;
    while (items_sent - start < target) begin
      send_message(pick_length());
    end
    wait_drained();
  endtask

  // The output is held off while further messages are offered, so the engine
  // finishes a digest, stalls on its output and stops taking input.
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    send_message(5);
    send_message(3);
    send_message(17);
    wait_drained();
    send_message(0);
    wait_drained();
  endtask

  initial begin
    clear_hash_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_messages();
    test_random_messages(62, 16, 75);
    test_random_messages(62, 75, 16);
    test_output_backpressure();
    test_random_messages(62, 0, 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && digest_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/md2he_pkg.sv
rtl/core/md2he_ram.sv
rtl/core/md2_hash_engine.sv
test/md2_hash_engine_tb.sv
